/* rtl/assert_macros.svh */
// assertion macros used by the checker file erq_checker.sv
// no dependencies; clock and reset are taken from the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that also holds while reset is high
`define ERQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// check that is switched off while reset is high
`define ERQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

/* rtl/erq_pkg.sv */
// types, constants and fixed point scaling for the euler to quaternion block
// no dependencies
package erq_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int OUT_FRAC_BITS   = 15;
   localparam int HALF_FRAC       = ANGLE_FRAC_BITS + 1;

   // half angle units: 2^-HALF_FRAC degree
   localparam logic [15:0] TURN      = 16'(360 << HALF_FRAC);
   localparam logic [15:0] QUARTER   = 16'(90 << HALF_FRAC);
   localparam logic [15:0] QUARTER_2 = 16'(180 << HALF_FRAC);
   localparam logic [15:0] QUARTER_3 = 16'(270 << HALF_FRAC);
   localparam logic [13:0] QUARTER_A = 14'(90 << HALF_FRAC);
   localparam logic [13:0] EIGHTH_A  = 14'(45 << HALF_FRAC);

   // degrees to radians: x = fa * RAD_Q + round((fa * RAD_R) / RAD_DEN)
   localparam longint unsigned PI_Q40  = 64'h3243F6A8886;
   localparam longint unsigned RAD_DEN = 64'd180 << (HALF_FRAC + 10);
   localparam logic [17:0] RAD_Q       = 18'(PI_Q40 / RAD_DEN);
   localparam logic [24:0] RAD_R       = 25'(PI_Q40 % RAD_DEN);
   localparam logic [37:0] RAD_HALF    = 38'(RAD_DEN / 64'd2);
   // RAD_DEN = 45 << RAD_SHIFT
   localparam int RAD_SHIFT            = HALF_FRAC + 12;
   localparam int RCP_SHIFT            = 24;
   localparam logic [18:0] RCP45       = 19'(((64'd1 << RCP_SHIFT) + 64'd44) / 64'd45);

   localparam int X_W = 30;

   // q2.30 arithmetic
   localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
   localparam longint unsigned Q30_HALF = 64'd1 << 29;

   // taylor ratios as reciprocals, exact for dividends below 2^30
   localparam int SIN_STEPS = 4;
   localparam int COS_STEPS = 5;
   localparam int SIN_K [SIN_STEPS] = '{37, 36, 35, 33};
   localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
      32'(((64'd1 << 37) + 64'd71) / 64'd72),
      32'(((64'd1 << 36) + 64'd41) / 64'd42),
      32'(((64'd1 << 35) + 64'd19) / 64'd20),
      32'(((64'd1 << 33) + 64'd5) / 64'd6)
   };
   localparam int COS_K [COS_STEPS] = '{37, 36, 35, 34, 31};
   localparam logic [31:0] COS_RCP [COS_STEPS] = '{
      32'(((64'd1 << 37) + 64'd89) / 64'd90),
      32'(((64'd1 << 36) + 64'd55) / 64'd56),
      32'(((64'd1 << 35) + 64'd29) / 64'd30),
      32'(((64'd1 << 34) + 64'd11) / 64'd12),
      32'(((64'd1 << 31) + 64'd1) / 64'd2)
   };

   // output rescale from q2.30
   localparam int OUT_SHIFT             = 30 - OUT_FRAC_BITS;
   localparam longint unsigned OUT_RND  = 64'd1 << (OUT_SHIFT - 1);
   localparam logic [17:0] SAT_POS      = 18'd32767;
   localparam logic [17:0] SAT_NEG      = 18'd32768;

   // pipeline depths
   localparam int FRONT_DEPTH = 6;
   localparam int LANE_LAT    = 14;
   localparam int BACK_LAT    = LANE_LAT + 6;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);

   typedef struct packed {
      logic signed [15:0] roll_deg;
      logic signed [15:0] pitch_deg;
      logic signed [15:0] yaw_deg;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   // one folded half angle: radians in q0.30, quadrant, octant swap
   typedef struct packed {
      logic [X_W-1:0] x;
      logic [1:0]     quad;
      logic           swap;
   } arg_type;

   // index 0 roll, 1 pitch, 2 yaw
   typedef arg_type [2:0] item_type;

   // sine and cosine as sign and magnitude
   typedef struct packed {
      logic        s_neg;
      logic [30:0] s_mag;
      logic        c_neg;
      logic [30:0] c_mag;
   } sc_type;

endpackage

/* rtl/erq_front.sv */
// front pipeline: accepts requests, reduces and folds the half angles,
// converts them to radians; uses erq_pkg
module erq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  erq_pkg::req_type  req_data,
   output logic              out_valid,
   output erq_pkg::item_type out_item,
   input  logic              out_ready
);

   logic [erq_pkg::FRONT_DEPTH-1:0] vld_ff;
   logic                            en;
   logic signed [15:0]              ang [3];

   assign en        = !vld_ff[erq_pkg::FRONT_DEPTH-1] || out_ready;
   assign req_ready = en;
   assign out_valid = vld_ff[erq_pkg::FRONT_DEPTH-1];

   assign ang[0] = req_data.roll_deg;
   assign ang[1] = req_data.pitch_deg;
   assign ang[2] = req_data.yaw_deg;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[erq_pkg::FRONT_DEPTH-2:0], req_valid};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_ang
      logic [15:0]          r_ff, r_in;
      logic [1:0]           q2_ff, q2_in;
      logic [13:0]          a2_ff, a2_in;
      logic [1:0]           q3_ff;
      logic                 s3_ff, s3_in;
      logic [12:0]          fa_ff, fa_in;
      logic [1:0]           q4_ff;
      logic                 s4_ff;
      logic [29:0]          fq4_ff, fq4_in;
      logic [37:0]          fr_ff, fr_in;
      logic [1:0]           q5_ff;
      logic                 s5_ff;
      logic [29:0]          fq5_ff;
      logic [18:0]          z;
      logic [37:0]          zc_ff, zc_in;
      logic [1:0]           q6_ff;
      logic                 s6_ff;
      logic [erq_pkg::X_W-1:0] x_ff, x_in;

      always_comb begin
         // wrap a negative half angle up by one turn (16-bit wrap does it)
         r_in = ang[i][15] ? 16'(unsigned'(ang[i]) + erq_pkg::TURN) : unsigned'(ang[i]);

         if (r_ff >= erq_pkg::QUARTER_3) begin
            q2_in = 2'd3;
            a2_in = 14'(r_ff - erq_pkg::QUARTER_3);
         end else if (r_ff >= erq_pkg::QUARTER_2) begin
            q2_in = 2'd2;
            a2_in = 14'(r_ff - erq_pkg::QUARTER_2);
         end else if (r_ff >= erq_pkg::QUARTER) begin
            q2_in = 2'd1;
            a2_in = 14'(r_ff - erq_pkg::QUARTER);
         end else begin
            q2_in = 2'd0;
            a2_in = 14'(r_ff);
         end

         // above the octant, work on the complement
         s3_in = a2_ff > erq_pkg::EIGHTH_A;
         fa_in = s3_in ? 13'(erq_pkg::QUARTER_A - a2_ff) : 13'(a2_ff);

         fq4_in = 30'(30'(fa_ff) * 30'(erq_pkg::RAD_Q));
         fr_in  = 38'(38'(fa_ff) * 38'(erq_pkg::RAD_R)) + erq_pkg::RAD_HALF;

         z      = 19'(fr_ff >> erq_pkg::RAD_SHIFT);
         zc_in  = 38'(38'(z) * 38'(erq_pkg::RCP45));

         x_in   = 30'(fq5_ff + 30'(zc_ff >> erq_pkg::RCP_SHIFT));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff   <= r_in;
            q2_ff  <= q2_in;
            a2_ff  <= a2_in;
            q3_ff  <= q2_ff;
            s3_ff  <= s3_in;
            fa_ff  <= fa_in;
            q4_ff  <= q3_ff;
            s4_ff  <= s3_ff;
            fq4_ff <= fq4_in;
            fr_ff  <= fr_in;
            q5_ff  <= q4_ff;
            s5_ff  <= s4_ff;
            fq5_ff <= fq4_ff;
            zc_ff  <= zc_in;
            q6_ff  <= q5_ff;
            s6_ff  <= s5_ff;
            x_ff   <= x_in;
         end
      end

      assign out_item[i].x    = x_ff;
      assign out_item[i].quad = q6_ff;
      assign out_item[i].swap = s6_ff;
   end

endmodule

/* rtl/erq_queue.sv */
// short register queue between the front and back pipelines
// uses erq_pkg
module erq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  erq_pkg::item_type in_item,
   output logic              out_valid,
   output erq_pkg::item_type out_item,
   input  logic              out_pop
);

   erq_pkg::item_type            mem_ff [erq_pkg::QDEPTH];
   logic [erq_pkg::QPTR_W-1:0]   wr_ff, rd_ff;
   logic [erq_pkg::QPTR_W:0]     cnt_ff;
   logic                         full, push, pop;

   assign full      = cnt_ff == (erq_pkg::QPTR_W + 1)'(erq_pkg::QDEPTH);
   assign in_ready  = !full || out_pop;
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

/* rtl/erq_sincos.sv */
// one sine/cosine lane: horner polynomials over pipelined multiply stages
// uses erq_pkg
module erq_sincos (
   input  logic             clock,
   input  logic             en,
   input  erq_pkg::arg_type in_arg,
   output erq_pkg::sc_type  out_sc
);

   logic [29:0] x_ff  [1:11];
   logic [29:0] x2_ff [3:11];
   logic [1:0]  q_ff  [1:13];
   logic        sw_ff [1:13];
   logic [59:0] p0_ff;
   logic [60:0] sp_ff;
   logic [30:0] sin_ff;
   logic [30:0] tc [0:erq_pkg::COS_STEPS];
   logic [30:0] ts [0:erq_pkg::SIN_STEPS];
   logic [30:0] os, oc;
   erq_pkg::sc_type out_ff, out_in;

   assign tc[0] = erq_pkg::Q30_ONE;
   assign ts[0] = erq_pkg::Q30_ONE;

   // t = 1 - round(x2 * t) / ratio, two stages per step
   for (genvar k = 1; k <= erq_pkg::COS_STEPS; k++) begin : g_cos
      logic [60:0] p_ff;
      logic [62:0] m_ff;
      logic [30:0] m;
      assign m = 31'((p_ff + 61'(erq_pkg::Q30_HALF)) >> 30);
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff <= 61'(61'(x2_ff[2*k+1]) * 61'(tc[k-1]));
            m_ff <= 63'(63'(m) * 63'(erq_pkg::COS_RCP[k-1]));
         end
      end
      assign tc[k] = erq_pkg::Q30_ONE - 31'(m_ff >> erq_pkg::COS_K[k-1]);
   end

   for (genvar k = 1; k <= erq_pkg::SIN_STEPS; k++) begin : g_sin
      logic [60:0] p_ff;
      logic [62:0] m_ff;
      logic [30:0] m;
      assign m = 31'((p_ff + 61'(erq_pkg::Q30_HALF)) >> 30);
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff <= 61'(61'(x2_ff[2*k+1]) * 61'(ts[k-1]));
            m_ff <= 63'(63'(m) * 63'(erq_pkg::SIN_RCP[k-1]));
         end
      end
      assign ts[k] = erq_pkg::Q30_ONE - 31'(m_ff >> erq_pkg::SIN_K[k-1]);
   end

   always_comb begin
      os = sw_ff[13] ? tc[erq_pkg::COS_STEPS] : sin_ff;
      oc = sw_ff[13] ? sin_ff : tc[erq_pkg::COS_STEPS];
      out_in = '0;
      case (q_ff[13])
         2'd0: begin
            out_in = '{s_neg: 1'b0, s_mag: os, c_neg: 1'b0, c_mag: oc};
         end
         2'd1: begin
            out_in = '{s_neg: 1'b0, s_mag: oc, c_neg: 1'b1, c_mag: os};
         end
         2'd2: begin
            out_in = '{s_neg: 1'b1, s_mag: os, c_neg: 1'b1, c_mag: oc};
         end
         2'd3: begin
            out_in = '{s_neg: 1'b1, s_mag: oc, c_neg: 1'b0, c_mag: os};
         end
         default: begin
            out_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[1]  <= in_arg.x;
         q_ff[1]  <= in_arg.quad;
         sw_ff[1] <= in_arg.swap;
         for (int s = 2; s <= 11; s++) begin
            x_ff[s] <= x_ff[s-1];
         end
         for (int s = 2; s <= 13; s++) begin
            q_ff[s]  <= q_ff[s-1];
            sw_ff[s] <= sw_ff[s-1];
         end
         p0_ff    <= 60'(60'(x_ff[1]) * 60'(x_ff[1]));
         x2_ff[3] <= 30'((p0_ff + 60'(erq_pkg::Q30_HALF)) >> 30);
         for (int s = 4; s <= 11; s++) begin
            x2_ff[s] <= x2_ff[s-1];
         end
         sp_ff  <= 61'(61'(x_ff[11]) * 61'(ts[erq_pkg::SIN_STEPS]));
         sin_ff <= 31'((sp_ff + 61'(erq_pkg::Q30_HALF)) >> 30);
         out_ff <= out_in;
      end
   end

   assign out_sc = out_ff;

endmodule

/* rtl/erq_back.sv */
// back pipeline: three sine/cosine lanes, triple products, sums, rescale
// uses erq_pkg and erq_sincos
module erq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  erq_pkg::item_type in_item,
   output logic              in_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output erq_pkg::rsp_type  rsp_data
);

   logic [erq_pkg::BACK_LAT-1:0] vld_ff;
   logic                         en;
   erq_pkg::sc_type              sc [3];
   erq_pkg::sc_type              pit_ff;
   logic [61:0]                  pm_ff [4];
   logic                         pn_ff [4];
   logic [30:0]                  pr [4];
   logic [61:0]                  tm_ff [8];
   logic                         tn_ff [8];
   logic [30:0]                  tr [8];
   logic signed [31:0]           tv_ff [8];
   logic signed [32:0]           sum_ff [4];
   logic                         neg_ff [4];
   logic [31:0]                  mag_ff [4];
   logic [17:0]                  om [4];
   logic signed [15:0]           sat [4];
   erq_pkg::rsp_type             rsp_ff;

   assign en        = !vld_ff[erq_pkg::BACK_LAT-1] || rsp_ready;
   assign in_pop    = en && in_valid;
   assign rsp_valid = vld_ff[erq_pkg::BACK_LAT-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[erq_pkg::BACK_LAT-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      erq_sincos u_lane (
         .clock  (clock),
         .en     (en),
         .in_arg (in_item[i]),
         .out_sc (sc[i])
      );
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         pr[j] = 31'((pm_ff[j] + 62'(erq_pkg::Q30_HALF)) >> 30);
      end
      for (int j = 0; j < 8; j++) begin
         tr[j] = 31'((tm_ff[j] + 62'(erq_pkg::Q30_HALF)) >> 30);
      end
      for (int j = 0; j < 4; j++) begin
         om[j] = 18'((mag_ff[j] + 32'(erq_pkg::OUT_RND)) >> erq_pkg::OUT_SHIFT);
         if (neg_ff[j]) begin
            sat[j] = (om[j] > erq_pkg::SAT_NEG) ? 16'sh8000 : 16'(18'd0 - om[j]);
         end else begin
            sat[j] = (om[j] > erq_pkg::SAT_POS) ? 16'sh7fff : 16'(om[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // pair products: cy*cr, sy*sr, cy*sr, sy*cr
         pm_ff[0] <= 62'(62'(sc[2].c_mag) * 62'(sc[0].c_mag));
         pn_ff[0] <= sc[2].c_neg ^ sc[0].c_neg;
         pm_ff[1] <= 62'(62'(sc[2].s_mag) * 62'(sc[0].s_mag));
         pn_ff[1] <= sc[2].s_neg ^ sc[0].s_neg;
         pm_ff[2] <= 62'(62'(sc[2].c_mag) * 62'(sc[0].s_mag));
         pn_ff[2] <= sc[2].c_neg ^ sc[0].s_neg;
         pm_ff[3] <= 62'(62'(sc[2].s_mag) * 62'(sc[0].c_mag));
         pn_ff[3] <= sc[2].s_neg ^ sc[0].c_neg;
         pit_ff   <= sc[1];

         // triple products, ordered w1 w2 x1 x2 y1 y2 z1 z2
         tm_ff[0] <= 62'(62'(pr[0]) * 62'(pit_ff.c_mag));
         tn_ff[0] <= pn_ff[0] ^ pit_ff.c_neg;
         tm_ff[1] <= 62'(62'(pr[1]) * 62'(pit_ff.s_mag));
         tn_ff[1] <= pn_ff[1] ^ pit_ff.s_neg;
         tm_ff[2] <= 62'(62'(pr[2]) * 62'(pit_ff.c_mag));
         tn_ff[2] <= pn_ff[2] ^ pit_ff.c_neg;
         tm_ff[3] <= 62'(62'(pr[3]) * 62'(pit_ff.s_mag));
         tn_ff[3] <= pn_ff[3] ^ pit_ff.s_neg;
         tm_ff[4] <= 62'(62'(pr[0]) * 62'(pit_ff.s_mag));
         tn_ff[4] <= pn_ff[0] ^ pit_ff.s_neg;
         tm_ff[5] <= 62'(62'(pr[1]) * 62'(pit_ff.c_mag));
         tn_ff[5] <= pn_ff[1] ^ pit_ff.c_neg;
         tm_ff[6] <= 62'(62'(pr[3]) * 62'(pit_ff.c_mag));
         tn_ff[6] <= pn_ff[3] ^ pit_ff.c_neg;
         tm_ff[7] <= 62'(62'(pr[2]) * 62'(pit_ff.s_mag));
         tn_ff[7] <= pn_ff[2] ^ pit_ff.s_neg;

         for (int j = 0; j < 8; j++) begin
            tv_ff[j] <= tn_ff[j] ? signed'(32'd0 - 32'(tr[j])) : signed'(32'(tr[j]));
         end

         sum_ff[0] <= 33'(tv_ff[0]) + 33'(tv_ff[1]);
         sum_ff[1] <= 33'(tv_ff[2]) - 33'(tv_ff[3]);
         sum_ff[2] <= 33'(tv_ff[4]) + 33'(tv_ff[5]);
         sum_ff[3] <= 33'(tv_ff[6]) - 33'(tv_ff[7]);

         for (int j = 0; j < 4; j++) begin
            neg_ff[j] <= sum_ff[j][32];
            mag_ff[j] <= sum_ff[j][32] ? 32'(33'd0 - unsigned'(sum_ff[j]))
                                       : 32'(unsigned'(sum_ff[j]));
         end

         rsp_ff.quat_w <= sat[0];
         rsp_ff.quat_x <= sat[1];
         rsp_ff.quat_y <= sat[2];
         rsp_ff.quat_z <= sat[3];
      end
   end

endmodule

/* rtl/euler_degrees_to_quaternion.sv */
// top level of the euler (z-y-x) to quaternion converter
// uses erq_pkg, erq_front, erq_queue, erq_back
//
// converts roll, pitch and yaw in degrees (signed, 6 fraction bits) to a unit
// quaternion w, x, y, z in signed q1.15, with +1.0 saturated to 32767. one
// request is taken every cycle while the front pipeline does not stall; the
// figure is set by the fully pipelined datapath, where every multiply feeds a
// register. a request passes through 6 front stages, the queue and 20
// back stages (14 in the sine/cosine lanes, 6 for products, sums and
// rescale). the front stages and the back stages each stall on their own; the
// four-entry queue between them absorbs the difference, and the block keeps
// no state from one request to the next.
module euler_degrees_to_quaternion (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  erq_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output erq_pkg::rsp_type rsp_data
);

   // front to queue
   logic              fr_valid;
   logic              fr_ready;
   erq_pkg::item_type fr_item;

   // queue to back
   logic              bk_valid;
   logic              bk_pop;
   erq_pkg::item_type bk_item;

   // angle reduction, octant fold and conversion to radians
   erq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (fr_valid),
      .out_item  (fr_item),
      .out_ready (fr_ready)
   );

   // decouples the two pipelines
   erq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (bk_valid),
      .out_item  (bk_item),
      .out_pop   (bk_pop)
   );

   // sine/cosine lanes, quaternion products and output register
   erq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bk_valid),
      .in_item   (bk_item),
      .in_pop    (bk_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/erq_checker.sv */
// port level checks for the euler to quaternion block, bound to its top level
// uses erq_pkg and assert_macros.svh
`include "assert_macros.svh"

module erq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input erq_pkg::rsp_type rsp_data
);

   // nothing in flight right after reset
   `ERQ_ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_valid, "rsp_valid after reset")
   // empty pipelines take a request at once
   `ERQ_ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_ready, "req_ready low after reset")
   // a stalled result stays offered
   `ERQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped")
   // and keeps its value
   `ERQ_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp_data moved")

endmodule

bind euler_degrees_to_quaternion erq_checker u_erq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
